// ===== src/bcpa_pkg.sv =====
// Shared types and constants for the first-fit bitmap page allocator.
// No dependencies; imported by bitmap_contiguous_page_allocator_top.
`default_nettype none

package bcpa_pkg;

   localparam int DEF_N_PAGES = 1024;
   localparam int WORD_BITS   = 32;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NO_SPACE = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [10:0] page_count;
      logic [9:0]  start_page;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [9:0] first_page;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/bitmap_contiguous_page_allocator_top.sv =====
// First-fit contiguous page allocator: usage bitmap in a word memory, word scanner,
// read-modify-write marker. Depends on bcpa_pkg.
`default_nettype none

// Usage
//  - req channel (req_valid / req_stall / req_data): one beat per request. kind
//    allocate searches from page 1 for page_count consecutive free pages; kind free
//    clears page_count pages from start_page (pages past the bitmap end ignored).
//  - rsp channel (rsp_valid / rsp_stall / rsp_data): exactly one beat per request,
//    in order. status no-space with first_page 0 on a failed allocate; frees
//    always report done with first_page 0.
//  - One request at a time: req_stall is high from acceptance until the result
//    is loaded into the output register. A result waiting on rsp_stall does not
//    block the next request; only the following result waits for it.
//  - Operation: the bitmap memory holds 32 pages per word with one registered read
//    port. An allocate scans one word per cycle, then marks each word touched with
//    a read (S_RMW_RD) and a write (S_RMW_WR), then hands the result off in S_RESP.
//    A free does the same read and write per word touched, then the same hand-off.
//  - Reset: a clearing pass writes every word (page 0 set, the rest clear),
//    during which req_stall is high.
//  - Receiver stall: the result stays in the output register unchanged until taken.

module bitmap_contiguous_page_allocator_top #(
   parameter int N_PAGES = bcpa_pkg::DEF_N_PAGES
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire bcpa_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output bcpa_pkg::rsp_type      rsp_data
);

   import bcpa_pkg::*;

   localparam int NUM_WORDS = (N_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int PAGE_W    = $clog2(N_PAGES);
   localparam int END_W     = ((PAGE_W > 11) ? PAGE_W : 11) + 2;
   localparam int WX_W      = END_W - 5;
   localparam int TAIL      = N_PAGES % WORD_BITS;
   localparam logic [31:0] TAIL_MASK =
      (TAIL == 0) ? 32'd0 : ~((32'd1 << TAIL) - 32'd1);
   localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(NUM_WORDS - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_RMW_RD,
      S_RMW_WR,
      S_RESP
   } state_type;

   // registers
   state_type         state_ff, state_in;
   logic [WORD_W-1:0] clr_ff, clr_in;
   logic [10:0]       count_ff, count_in;
   logic              set_ff, set_in;
   logic [END_W-1:0]  lo_ff, lo_in;
   logic [END_W-1:0]  last_ff, last_in;
   logic [WORD_W-1:0] rmw_w_ff, rmw_w_in;
   logic [WORD_W:0]   scan_rd_ff, scan_rd_in;
   logic              eval_vld_ff, eval_vld_in;
   logic [WORD_W-1:0] eval_w_ff, eval_w_in;
   logic [31:0]       prev_free_ff, prev_free_in;
   logic [11:0]       run_ff, run_in;
   logic              status_ff, status_in;
   logic [9:0]        first_ff, first_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // bitmap memory
   logic [31:0]       bitmap_mem [NUM_WORDS];
   logic [31:0]       mem_q_ff;
   logic              mem_we;
   logic [WORD_W-1:0] mem_wa;
   logic [WORD_W-1:0] mem_ra;
   logic [31:0]       mem_wd;

   // scan datapath
   logic [31:0]       used_w;
   logic [31:0]       free_w;
   logic [63:0]       win_p;
   logic [63:0]       win_acc;
   logic [31:0]       hit_vec;
   logic [4:0]        hit_pos;
   logic [5:0]        tz;
   logic [5:0]        lead;
   logic              short_run;
   logic              hit;
   logic [12:0]       run_sum;
   logic [END_W-1:0]  word_base;
   logic [END_W-1:0]  hit_first;
   logic [11:0]       run_next;

   // marker datapath
   logic [4:0]        lo_off;
   logic [4:0]        hi_off;
   logic [31:0]       rmw_mask;
   logic              rmw_last;

   logic              req_accept;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // word evaluation for the scan
   always_comb begin
      used_w = mem_q_ff
             | ((eval_w_ff == LAST_WORD) ? TAIL_MASK : 32'd0)
             | ((eval_w_ff == '0) ? 32'd1 : 32'd0);   // scan starts at page 1
      free_w = ~used_w;

      // short runs: window AND over {this word, previous word}, built from the
      // bits of the count with constant shifts
      win_p   = {free_w, prev_free_ff};
      win_acc = '1;
      for (int b = 0; b < 6; b++) begin
         if (count_ff[b]) begin
            win_acc = win_p & (win_acc << (1 << b));
         end
         win_p = win_p & (win_p << (1 << b));
      end
      hit_vec = win_acc[63:32];

      hit_pos = '0;
      for (int i = 31; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_pos = 5'(i);
         end
      end

      // long runs: carried run plus free bits at the bottom of this word
      tz = 6'd32;
      for (int i = 31; i >= 0; i--) begin
         if (used_w[i]) begin
            tz = 6'(i);
         end
      end
      lead = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (used_w[i]) begin
            lead = 6'(31 - i);
         end
      end

      short_run = (count_ff <= 11'd32);
      run_sum   = 13'(run_ff) + 13'(tz);
      word_base = END_W'({eval_w_ff, 5'd0});
      if (short_run) begin
         hit       = |hit_vec;
         hit_first = word_base + END_W'(hit_pos) + END_W'(1) - END_W'(count_ff);
      end else begin
         hit       = (run_sum >= 13'(count_ff));
         hit_first = word_base - END_W'(run_ff);
      end
      run_next = (lead == 6'd32) ? (run_ff + 12'd32) : 12'(lead);
   end

   // range mask for the word under read-modify-write
   always_comb begin
      lo_off   = (WX_W'(rmw_w_ff) == lo_ff[END_W-1:5]) ? lo_ff[4:0] : 5'd0;
      hi_off   = (WX_W'(rmw_w_ff) == last_ff[END_W-1:5]) ? last_ff[4:0] : 5'd31;
      rmw_mask = (32'hFFFF_FFFF << lo_off) & (32'hFFFF_FFFF >> (5'd31 - hi_off));
      rmw_last = (WX_W'(rmw_w_ff) == last_ff[END_W-1:5]) || (rmw_w_ff == LAST_WORD);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      count_in     = count_ff;
      set_in       = set_ff;
      lo_in        = lo_ff;
      last_in      = last_ff;
      rmw_w_in     = rmw_w_ff;
      scan_rd_in   = scan_rd_ff;
      eval_vld_in  = 1'b0;
      eval_w_in    = eval_w_ff;
      prev_free_in = prev_free_ff;
      run_in       = run_ff;
      status_in    = status_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = rmw_w_ff;
      mem_wd       = 32'd0;
      mem_ra       = rmw_w_ff;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = (clr_ff == '0) ? 32'd1 : 32'd0;   // page directory
            clr_in = clr_ff + WORD_W'(1);
            if (clr_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               count_in  = req_data.page_count;
               status_in = STATUS_OK;
               first_in  = '0;
               if (req_data.kind == KIND_FREE) begin
                  set_in   = 1'b0;
                  lo_in    = END_W'(req_data.start_page);
                  last_in  = END_W'(req_data.start_page) + END_W'(req_data.page_count)
                           - END_W'(1);
                  rmw_w_in = WORD_W'(req_data.start_page[9:5]);
                  if (req_data.page_count == '0 ||
                      WX_W'(req_data.start_page[9:5]) > WX_W'(LAST_WORD)) begin
                     state_in = S_RESP;
                  end else begin
                     state_in = S_RMW_RD;
                  end
               end else begin
                  set_in       = 1'b1;
                  scan_rd_in   = '0;
                  prev_free_in = '0;
                  run_in       = '0;
                  if (req_data.page_count == '0) begin
                     status_in = STATUS_NO_SPACE;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
            end
         end
         S_SCAN: begin
            mem_ra = scan_rd_ff[WORD_W-1:0];
            if (scan_rd_ff < (WORD_W+1)'(NUM_WORDS)) begin
               eval_vld_in = 1'b1;
               eval_w_in   = scan_rd_ff[WORD_W-1:0];
               scan_rd_in  = scan_rd_ff + (WORD_W+1)'(1);
            end
            if (eval_vld_ff) begin
               prev_free_in = free_w;
               run_in       = run_next;
               if (hit) begin
                  eval_vld_in = 1'b0;
                  lo_in       = hit_first;
                  last_in     = hit_first + END_W'(count_ff) - END_W'(1);
                  first_in    = hit_first[9:0];
                  rmw_w_in    = WORD_W'(hit_first[END_W-1:5]);
                  state_in    = S_RMW_RD;
               end else if (eval_w_ff == LAST_WORD) begin
                  eval_vld_in = 1'b0;
                  status_in   = STATUS_NO_SPACE;
                  state_in    = S_RESP;
               end
            end
         end
         S_RMW_RD: begin
            mem_ra   = rmw_w_ff;
            state_in = S_RMW_WR;
         end
         S_RMW_WR: begin
            mem_we = 1'b1;
            mem_wa = rmw_w_ff;
            mem_wd = set_ff ? (mem_q_ff | rmw_mask) : (mem_q_ff & ~rmw_mask);
            if (rmw_last) begin
               state_in = S_RESP;
            end else begin
               rmw_w_in = rmw_w_ff + WORD_W'(1);
               state_in = S_RMW_RD;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.status     = status_ff;
               rsp_data_in.first_page = first_ff;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         eval_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         eval_vld_ff  <= eval_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff     <= count_in;
      set_ff       <= set_in;
      lo_ff        <= lo_in;
      last_ff      <= last_in;
      rmw_w_ff     <= rmw_w_in;
      scan_rd_ff   <= scan_rd_in;
      eval_w_ff    <= eval_w_in;
      prev_free_ff <= prev_free_in;
      run_ff       <= run_in;
      status_ff    <= status_in;
      first_ff     <= first_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= bitmap_mem[mem_ra];
   end

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("block not busy after accepting a request");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid_ff)
      else $error("result presented during clearing pass");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !mem_we)
      else $error("bitmap written during scan");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("result loaded outside hand-off state");
`endif

endmodule

`default_nettype wire
